// ===== rtl/core/twhl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twhl_pkg
// Shared types and constants of the two-wire handshake link.
// ----------------------------------------------------------------------------
package twhl_pkg;

   // Sampled line levels packed as {A, B}, 1 = line high.
   typedef logic [1:0] line_level_type;

   localparam line_level_type LV_BOTH_HIGH = 2'b11;
   localparam line_level_type LV_ONLY_A    = 2'b10;
   localparam line_level_type LV_ONLY_B    = 2'b01;
   localparam line_level_type LV_BOTH_LOW  = 2'b00;

   // Bits in one transferred byte.
   localparam int BYTE_BITS = 8;

   // Handshake wait limit after reset.
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   // Send queue view offered to the link state machine.
   typedef struct packed {
      logic       nonempty;
      logic [7:0] head_data;
   } queue_status_type;

   // Link state machine part of one result transaction.
   typedef struct packed {
      logic       pull_a_low;
      logic       pull_b_low;
      logic       recv_valid;
      logic [7:0] recv_byte;
      logic [7:0] noise_tally;
      logic [7:0] timeout_tally;
      logic       link_busy;
   } link_result_type;

endpackage

// ===== rtl/core/twhl_send_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twhl_send_queue
// Circular byte queue for transmission with a registered head read.
// ----------------------------------------------------------------------------
module twhl_send_queue #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        pop,
   input  logic                        push,
   input  logic [7:0]                  push_byte,
   output twhl_pkg::queue_status_type  status,
   output logic                        overflow,
   output logic [4:0]                  fill
);
   import twhl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    head_data_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [LW-1:0] level_ff, level_in;
   logic          full;
   logic          do_pop;
   logic          do_push;

   // A byte leaves before the offered one is stored, so a full queue that is
   // read in the same transaction still takes the offer.
   assign full     = (level_ff == LW'(DEPTH));
   assign overflow = push && full && !pop;
   assign do_pop   = step && pop;
   assign do_push  = step && push && !(full && !pop);

   // Pointer and level update with wrap at the queue depth.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      level_in = level_ff;
      if (do_pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   // Storage write and head read; a byte written into the new head slot is
   // forwarded so the registered head always matches the stored entry.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= push_byte;
      end
      if (do_push && (tail_ff == head_in)) begin
         head_data_ff <= push_byte;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign status.nonempty  = (level_ff != '0);
   assign status.head_data = head_data_ff;
   assign fill             = 5'(level_in);

endmodule

// ===== rtl/core/twhl_link_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twhl_link_fsm
// Four-phase dual-rail handshake state machine for sending and receiving.
// ----------------------------------------------------------------------------
module twhl_link_fsm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  twhl_pkg::line_level_type    line_level,
   input  logic [15:0]                 timeout_ticks,
   input  twhl_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output twhl_pkg::link_result_type   result
);
   import twhl_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TX_READY,
      PH_TX_ACK,
      PH_TX_REL,
      PH_RX_ONE,
      PH_RX_ZERO,
      PH_RX_REL
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  recv_shift_ff, recv_shift_in;
   logic [2:0]  recv_bits_ff, recv_bits_in;
   logic [7:0]  send_shift_ff, send_shift_in;
   logic [3:0]  send_bits_ff, send_bits_in;
   logic [7:0]  noise_ff, noise_in;
   logic [7:0]  timeouts_ff, timeouts_in;
   logic [15:0] limit;
   logic [15:0] wait_inc;
   logic        expired;
   logic        rx_done;
   logic        rx_bit;
   logic        take_rx;

   // Shared wait timer: a zero limit behaves as one tick.
   assign limit    = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
   assign wait_inc = wait_ff + 16'd1;
   assign expired  = (wait_inc >= limit) || (wait_inc == 16'd0);

   // Next state of the handshake for the current transaction.
   always_comb begin
      phase_in      = phase_ff;
      wait_in       = wait_ff;
      recv_shift_in = recv_shift_ff;
      recv_bits_in  = recv_bits_ff;
      send_shift_in = send_shift_ff;
      send_bits_in  = send_bits_ff;
      noise_in      = noise_ff;
      timeouts_in   = timeouts_ff;
      pop           = 1'b0;
      take_rx       = 1'b0;
      rx_bit        = 1'b0;
      rx_done       = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (line_level == LV_ONLY_A) begin
               phase_in = PH_RX_ONE;
               wait_in  = '0;
            end else if (line_level == LV_ONLY_B) begin
               phase_in = PH_RX_ZERO;
               wait_in  = '0;
            end else if (line_level == LV_BOTH_LOW) begin
               noise_in = noise_ff + 8'd1;
            end else if (send_bits_ff != 4'd0) begin
               phase_in = PH_TX_ACK;
               wait_in  = '0;
            end else if (queue_status.nonempty) begin
               pop           = 1'b1;
               send_shift_in = queue_status.head_data;
               send_bits_in  = 4'(BYTE_BITS);
               phase_in      = PH_TX_ACK;
               wait_in       = '0;
            end
         end
         PH_TX_READY: begin
            if (line_level == LV_BOTH_HIGH) begin
               phase_in = PH_TX_ACK;
               wait_in  = '0;
            end else if (expired) begin
               timeouts_in = timeouts_ff + 8'd1;
               phase_in    = PH_TX_ACK;
               wait_in     = '0;
            end else begin
               wait_in = wait_inc;
            end
         end
         PH_TX_ACK: begin
            if ((line_level == LV_BOTH_LOW) || expired) begin
               if (line_level != LV_BOTH_LOW) begin
                  timeouts_in = timeouts_ff + 8'd1;
               end
               send_shift_in = send_shift_ff >> 1;
               if (send_bits_ff != 4'd0) begin
                  send_bits_in = send_bits_ff - 4'd1;
               end
               phase_in = PH_TX_REL;
               wait_in  = '0;
            end else begin
               wait_in = wait_inc;
            end
         end
         PH_TX_REL: begin
            if (line_level == LV_BOTH_HIGH) begin
               phase_in = (send_bits_ff != 4'd0) ? PH_TX_ACK : PH_IDLE;
               wait_in  = '0;
            end else if (expired) begin
               timeouts_in = timeouts_ff + 8'd1;
               phase_in    = (send_bits_ff != 4'd0) ? PH_TX_READY : PH_IDLE;
               wait_in     = '0;
            end else begin
               wait_in = wait_inc;
            end
         end
         PH_RX_ONE: begin
            if ((line_level == LV_ONLY_B) || expired) begin
               if (line_level != LV_ONLY_B) begin
                  timeouts_in = timeouts_ff + 8'd1;
               end
               take_rx = 1'b1;
               rx_bit  = 1'b1;
            end else begin
               wait_in = wait_inc;
            end
         end
         PH_RX_ZERO: begin
            if ((line_level == LV_ONLY_A) || expired) begin
               if (line_level != LV_ONLY_A) begin
                  timeouts_in = timeouts_ff + 8'd1;
               end
               take_rx = 1'b1;
               rx_bit  = 1'b0;
            end else begin
               wait_in = wait_inc;
            end
         end
         PH_RX_REL: begin
            if ((line_level == LV_BOTH_HIGH) || expired) begin
               if (line_level != LV_BOTH_HIGH) begin
                  timeouts_in = timeouts_ff + 8'd1;
               end
               phase_in = PH_IDLE;
               wait_in  = '0;
            end else begin
               wait_in = wait_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            wait_in  = '0;
         end
      endcase

      // Shift a received bit in, least significant bit first.
      if (take_rx) begin
         recv_shift_in = {rx_bit, recv_shift_ff[7:1]};
         phase_in      = PH_RX_REL;
         wait_in       = '0;
         if (recv_bits_ff == 3'(BYTE_BITS - 1)) begin
            rx_done      = 1'b1;
            recv_bits_in = '0;
         end else begin
            recv_bits_in = recv_bits_ff + 3'd1;
         end
      end
   end

   // State is held across idle cycles and advances once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         wait_ff       <= '0;
         recv_shift_ff <= '0;
         recv_bits_ff  <= '0;
         send_shift_ff <= '0;
         send_bits_ff  <= '0;
         noise_ff      <= '0;
         timeouts_ff   <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         wait_ff       <= wait_in;
         recv_shift_ff <= rx_done ? 8'd0 : recv_shift_in;
         recv_bits_ff  <= recv_bits_in;
         send_shift_ff <= send_shift_in;
         send_bits_ff  <= send_bits_in;
         noise_ff      <= noise_in;
         timeouts_ff   <= timeouts_in;
      end
   end

   // Drives and status reflect the state after this transaction.
   always_comb begin
      result.pull_a_low    = 1'b0;
      result.pull_b_low    = 1'b0;
      if (phase_in == PH_TX_ACK) begin
         result.pull_b_low = send_shift_in[0];
         result.pull_a_low = !send_shift_in[0];
      end else if (phase_in == PH_RX_ONE) begin
         result.pull_a_low = 1'b1;
      end else if (phase_in == PH_RX_ZERO) begin
         result.pull_b_low = 1'b1;
      end
      result.recv_valid    = rx_done;
      result.recv_byte     = rx_done ? recv_shift_in : 8'd0;
      result.noise_tally   = noise_in;
      result.timeout_tally = timeouts_in;
      result.link_busy     = (phase_in != PH_IDLE);
   end

endmodule

// ===== rtl/core/two_wire_handshake_link.sv =====
`timescale 1ns / 1ps
// A result transaction is presented in the cycle after its request is accepted.
// Throughput: one transaction per cycle; the single result register stalls the
// request side only while a held result is itself stalled.
// Reset: synchronous and active high; it clears the handshake state, counters and
// queue pointers and sets timeout_ticks to 100. Queue storage is not cleared.
// ----------------------------------------------------------------------------
// two_wire_handshake_link
// Dual-rail four-phase serial link over two open-drain lines with a send queue.
// ----------------------------------------------------------------------------
module two_wire_handshake_link #(
   parameter int SEND_QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_line_a_level,
   input  logic        req_line_b_level,
   input  logic        req_send_valid,
   input  logic [7:0]  req_send_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pull_a_low,
   output logic        rsp_pull_b_low,
   output logic        rsp_recv_valid,
   output logic [7:0]  rsp_recv_byte,
   output logic        rsp_queue_overflow,
   output logic [4:0]  rsp_queue_fill,
   output logic [7:0]  rsp_noise_tally,
   output logic [7:0]  rsp_timeout_tally,
   output logic        rsp_link_busy,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import twhl_pkg::*;

   logic             accept;
   logic             pop;
   queue_status_type queue_status;
   link_result_type  link_result;
   logic             overflow;
   logic [4:0]       fill;
   logic [15:0]      timeout_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   link_result_type  rsp_link_ff;
   logic             rsp_overflow_ff;
   logic [4:0]       rsp_fill_ff;

   // A request transaction is taken unless a held result is stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Timeout configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         timeout_ff <= csr_write_data;
      end
   end

   twhl_send_queue #(
      .DEPTH (SEND_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .pop       (pop),
      .push      (req_send_valid),
      .push_byte (req_send_byte),
      .status    (queue_status),
      .overflow  (overflow),
      .fill      (fill)
   );

   twhl_link_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .line_level    ({req_line_a_level, req_line_b_level}),
      .timeout_ticks (timeout_ff),
      .queue_status  (queue_status),
      .pop           (pop),
      .result        (link_result)
   );

   // Result register: loaded on accept, emptied when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_link_ff     <= link_result;
         rsp_overflow_ff <= overflow;
         rsp_fill_ff     <= fill;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pull_a_low     = rsp_link_ff.pull_a_low;
   assign rsp_pull_b_low     = rsp_link_ff.pull_b_low;
   assign rsp_recv_valid     = rsp_link_ff.recv_valid;
   assign rsp_recv_byte      = rsp_link_ff.recv_byte;
   assign rsp_queue_overflow = rsp_overflow_ff;
   assign rsp_queue_fill     = rsp_fill_ff;
   assign rsp_noise_tally    = rsp_link_ff.noise_tally;
   assign rsp_timeout_tally  = rsp_link_ff.timeout_tally;
   assign rsp_link_busy      = rsp_link_ff.link_busy;

   // The block never drives both lines low at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pull_a_low && rsp_pull_b_low))
      else $error("both line drives active");

   // With no transfer in progress both lines are released.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_link_busy) |-> (!rsp_pull_a_low && !rsp_pull_b_low))
      else $error("line driven while link idle");

   // The received byte reads zero unless a byte completed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_recv_valid) |-> (rsp_recv_byte == 8'd0))
      else $error("received byte set without completion");

   // Every accepted request yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-wire handshake link testbench
// Drives sampled line levels and send offers into the link one transaction
// per tick. An emulated partner follows the block's handshake phases, with
// noise, slow partners and abandoned waits mixed in. A cycle-level predictor
// computes each result transaction, and a checker compares every field.
// ----------------------------------------------------------------------------
module testbench;
   import twhl_pkg::*;

   localparam int QUEUE_DEPTH = 16;

   // Handshake phases of the predicted link state machine.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TX_WAIT_IDLE,
      ST_TX_DRIVE,
      ST_TX_RELEASE,
      ST_RX_ONE,
      ST_RX_ZERO,
      ST_RX_RELEASE
   } link_phase_type;

   // One predicted result transaction.
   typedef struct packed {
      link_result_type link;
      logic            queue_overflow;
      logic [4:0]      queue_fill;
   } tick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_line_a_level = 1'b1;
   logic        req_line_b_level = 1'b1;
   logic        req_send_valid = 1'b0;
   logic [7:0]  req_send_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_pull_a_low;
   logic        rsp_pull_b_low;
   logic        rsp_recv_valid;
   logic [7:0]  rsp_recv_byte;
   logic        rsp_queue_overflow;
   logic [4:0]  rsp_queue_fill;
   logic [7:0]  rsp_noise_tally;
   logic [7:0]  rsp_timeout_tally;
   logic        rsp_link_busy;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'd0;

   // Predicted link state, starting from its reset values.
   link_phase_type link_phase = ST_IDLE;
   logic [15:0] timeout_limit = TIMEOUT_RESET;
   logic [15:0] wait_count = 16'd0;
   logic [7:0]  rx_shift = 8'd0;
   logic [3:0]  rx_count = 4'd0;
   logic [7:0]  tx_shift = 8'd0;
   logic [3:0]  tx_left = 4'd0;
   logic [7:0]  noise_count = 8'd0;
   logic [7:0]  timeout_count = 8'd0;
   logic [7:0]  fifo_mem [QUEUE_DEPTH];
   logic [3:0]  fifo_rd = 4'd0;
   logic [3:0]  fifo_wr = 4'd0;
   logic [4:0]  fifo_level = 5'd0;

   // Emulated partner state.
   link_phase_type seen_phase = ST_IDLE;
   int          phase_hold = 0;
   logic [7:0]  partner_byte = 8'd0;
   int          partner_bits = 0;

   tick_result_type expected_results [$];
   tick_result_type oldest_result;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          rsp_hold_request = 0;
   int          mismatch_count = 0;
   int          sent_count = 0;
   int          checked_count = 0;
   int          bytes_received = 0;
   int          overflow_count = 0;

   two_wire_handshake_link #(
      .SEND_QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_line_a_level(req_line_a_level),
      .req_line_b_level(req_line_b_level),
      .req_send_valid(req_send_valid),
      .req_send_byte(req_send_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pull_a_low(rsp_pull_a_low),
      .rsp_pull_b_low(rsp_pull_b_low),
      .rsp_recv_valid(rsp_recv_valid),
      .rsp_recv_byte(rsp_recv_byte),
      .rsp_queue_overflow(rsp_queue_overflow),
      .rsp_queue_fill(rsp_queue_fill),
      .rsp_noise_tally(rsp_noise_tally),
      .rsp_timeout_tally(rsp_timeout_tally),
      .rsp_link_busy(rsp_link_busy),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   // Counts one failed wait tick and reports whether the wait is abandoned.
   function automatic logic wait_abandoned();
      logic [15:0] limit;
      limit = (timeout_limit == 16'd0) ? 16'd1 : timeout_limit;
      wait_count = wait_count + 16'd1;
      if (wait_count >= limit || wait_count == 16'd0) begin
         timeout_count = timeout_count + 8'd1;
         wait_count = 16'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void enter_phase(input link_phase_type next_phase);
      link_phase = next_phase;
      wait_count = 16'd0;
   endfunction

   // Shifts one received bit in, LSB first, and flags a completed byte.
   function automatic void accept_rx_bit(input logic rx_value, inout tick_result_type r);
      rx_shift = {rx_value, rx_shift[7:1]};
      rx_count = rx_count + 4'd1;
      if (rx_count >= 4'd8) begin
         r.link.recv_valid = 1'b1;
         r.link.recv_byte = rx_shift;
         rx_shift = 8'd0;
         rx_count = 4'd0;
         bytes_received++;
      end
      enter_phase(ST_RX_RELEASE);
   endfunction

   function automatic void end_tx_bit();
      tx_shift = tx_shift >> 1;
      if (tx_left > 4'd0) begin
         tx_left = tx_left - 4'd1;
      end
      enter_phase(ST_TX_RELEASE);
   endfunction

   // Advances the predicted link by one tick and returns its result.
   function automatic tick_result_type predict_tick(input line_level_type lv,
                                                    input logic offer,
                                                    input logic [7:0] offer_byte);
      tick_result_type r;
      r = '0;
      case (link_phase)
         ST_IDLE: begin
            if (lv == LV_ONLY_A) begin
               enter_phase(ST_RX_ONE);
            end else if (lv == LV_ONLY_B) begin
               enter_phase(ST_RX_ZERO);
            end else if (lv == LV_BOTH_LOW) begin
               noise_count = noise_count + 8'd1;
            end else if (tx_left > 4'd0) begin
               enter_phase(ST_TX_DRIVE);
            end else if (fifo_level > 5'd0) begin
               tx_shift = fifo_mem[fifo_rd];
               fifo_rd = fifo_rd + 4'd1;
               fifo_level = fifo_level - 5'd1;
               tx_left = 4'(BYTE_BITS);
               enter_phase(ST_TX_DRIVE);
            end
         end
         ST_TX_WAIT_IDLE: begin
            if (lv == LV_BOTH_HIGH) begin
               enter_phase(ST_TX_DRIVE);
            end else if (wait_abandoned()) begin
               enter_phase(ST_TX_DRIVE);
            end
         end
         ST_TX_DRIVE: begin
            if (lv == LV_BOTH_LOW) begin
               end_tx_bit();
            end else if (wait_abandoned()) begin
               end_tx_bit();
            end
         end
         ST_TX_RELEASE: begin
            if (lv == LV_BOTH_HIGH) begin
               enter_phase(tx_left > 4'd0 ? ST_TX_DRIVE : ST_IDLE);
            end else if (wait_abandoned()) begin
               enter_phase(tx_left > 4'd0 ? ST_TX_WAIT_IDLE : ST_IDLE);
            end
         end
         ST_RX_ONE: begin
            if (lv == LV_ONLY_B) begin
               accept_rx_bit(1'b1, r);
            end else if (wait_abandoned()) begin
               accept_rx_bit(1'b1, r);
            end
         end
         ST_RX_ZERO: begin
            if (lv == LV_ONLY_A) begin
               accept_rx_bit(1'b0, r);
            end else if (wait_abandoned()) begin
               accept_rx_bit(1'b0, r);
            end
         end
         ST_RX_RELEASE: begin
            if (lv == LV_BOTH_HIGH) begin
               enter_phase(ST_IDLE);
            end else if (wait_abandoned()) begin
               enter_phase(ST_IDLE);
            end
         end
         default: begin
            enter_phase(ST_IDLE);
         end
      endcase

      // The head byte is taken above before the offered byte is stored.
      if (offer) begin
         if (fifo_level >= QUEUE_DEPTH) begin
            r.queue_overflow = 1'b1;
            overflow_count++;
         end else begin
            fifo_mem[fifo_wr] = offer_byte;
            fifo_wr = fifo_wr + 4'd1;
            fifo_level = fifo_level + 5'd1;
         end
      end

      // Drives reflect the phase after the tick.
      if (link_phase == ST_TX_DRIVE) begin
         r.link.pull_b_low = tx_shift[0];
         r.link.pull_a_low = ~tx_shift[0];
      end else if (link_phase == ST_RX_ONE) begin
         r.link.pull_a_low = 1'b1;
      end else if (link_phase == ST_RX_ZERO) begin
         r.link.pull_b_low = 1'b1;
      end
      r.queue_fill = fifo_level;
      r.link.noise_tally = noise_count;
      r.link.timeout_tally = timeout_count;
      r.link.link_busy = (link_phase != ST_IDLE);
      return r;
   endfunction

   // Usually a short partner delay, sometimes a long one that can end in a timeout.
   function automatic int pick_delay();
      if ($urandom_range(99) < 10) begin
         return $urandom_range(12, 3);
      end
      return $urandom_range(2);
   endfunction

   function automatic line_level_type one_line_low();
      return $urandom_range(1) ? LV_ONLY_A : LV_ONLY_B;
   endfunction

   // Line levels a cooperative partner would show in the current phase.
   function automatic line_level_type choose_levels(input int noise_pct);
      logic held;
      line_level_type lv;
      if ($urandom_range(99) < noise_pct) begin
         return line_level_type'($urandom_range(3));
      end
      if (link_phase != seen_phase) begin
         seen_phase = link_phase;
         phase_hold = pick_delay();
      end
      held = (phase_hold > 0);
      if (held) begin
         phase_hold--;
      end
      lv = LV_BOTH_HIGH;
      case (link_phase)
         ST_IDLE: begin
            if (partner_bits == 0 && $urandom_range(99) < 25) begin
               partner_byte = 8'($urandom);
               partner_bits = BYTE_BITS;
            end
            if (partner_bits > 0 && $urandom_range(99) < 60) begin
               lv = partner_byte[0] ? LV_ONLY_A : LV_ONLY_B;
               partner_byte = partner_byte >> 1;
               partner_bits--;
            end
         end
         ST_RX_ONE:  lv = held ? LV_BOTH_LOW : LV_ONLY_B;
         ST_RX_ZERO: lv = held ? LV_BOTH_LOW : LV_ONLY_A;
         ST_TX_DRIVE: begin
            if (held) begin
               lv = tx_shift[0] ? LV_ONLY_A : LV_ONLY_B;
            end else begin
               lv = LV_BOTH_LOW;
            end
         end
         default: lv = held ? one_line_low() : LV_BOTH_HIGH;
      endcase
      return lv;
   endfunction

   // Offers one request transaction and records its expected result.
   task automatic send_tick(input line_level_type lv, input logic offer,
                            input logic [7:0] offer_byte);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_a_level <= lv[1];
      req_line_b_level <= lv[0];
      req_send_valid <= offer;
      req_send_byte <= offer_byte;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_tick(lv, offer, offer_byte));
      sent_count++;
   endtask

   // Stops offering and waits until every result transaction has arrived.
   task automatic settle_link();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_limit = value;
   endtask

   // Extremes of the send byte, noise, clean and abandoned waits, zero timeout.
   task automatic test_directed_cases();
      write_timeout(16'd0);
      send_tick(LV_BOTH_HIGH, 1'b0, 8'h00);
      send_tick(LV_BOTH_LOW, 1'b1, 8'hFF);
      send_tick(LV_BOTH_HIGH, 1'b1, 8'h00);
      send_tick(LV_ONLY_A, 1'b0, 8'h00);
      send_tick(LV_ONLY_A, 1'b0, 8'h00);
      send_tick(LV_BOTH_LOW, 1'b0, 8'h00);
      send_tick(LV_BOTH_LOW, 1'b0, 8'h00);
      send_tick(LV_BOTH_HIGH, 1'b0, 8'h00);
      settle_link();
      write_timeout(TIMEOUT_RESET);
      // Let the partner finish the byte in flight.
      while (link_phase != ST_IDLE) begin
         send_tick(choose_levels(0), 1'b0, 8'h00);
      end
      // Receive a one and a zero while a byte waits in the queue.
      send_tick(LV_ONLY_A, 1'b0, 8'h00);
      send_tick(LV_BOTH_LOW, 1'b0, 8'h00);
      send_tick(LV_ONLY_B, 1'b0, 8'h00);
      send_tick(LV_BOTH_HIGH, 1'b0, 8'h00);
      send_tick(LV_ONLY_B, 1'b0, 8'h00);
      send_tick(LV_ONLY_A, 1'b0, 8'h00);
      send_tick(LV_ONLY_A, 1'b0, 8'h00);
      send_tick(LV_BOTH_HIGH, 1'b0, 8'h00);
   endtask

   task automatic run_traffic(input int count, input int noise_pct, input int offer_pct);
      for (int i = 0; i < count; i++) begin
         send_tick(choose_levels(noise_pct), $urandom_range(99) < offer_pct, 8'($urandom));
      end
   endtask

   // Sweeps the wait limit through its extremes with traffic under each.
   task automatic test_timeout_settings();
      logic [15:0] limits [5];
      limits[0] = 16'd1;
      limits[1] = 16'd3;
      limits[2] = 16'hFFFF;
      limits[3] = 16'($urandom_range(40, 2));
      limits[4] = TIMEOUT_RESET;
      foreach (limits[i]) begin
         settle_link();
         write_timeout(limits[i]);
         run_traffic(30, 10, 8);
      end
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      run_traffic(110, 10, 8);
   endtask

   // The receiver holds off while offers keep coming, filling the block and the queue.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rsp_hold_request = 300;
      for (int i = 0; i < 60; i++) begin
         send_tick(LV_BOTH_LOW, 1'b1, 8'($urandom));
      end
      settle_link();
   endtask

   // Receiver stall: random, or a long counted hold-off on request.
   always @(posedge clock) begin : rsp_stall_gen
      int hold_cycles;
      if (rsp_hold_request > 0) begin
         hold_cycles = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   // Each accepted result transaction is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transaction arrived with no expectation pending");
            mismatch_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            checked_count++;
            check_field("pull_a_low", 8'(oldest_result.link.pull_a_low),
                        8'(rsp_pull_a_low));
            check_field("pull_b_low", 8'(oldest_result.link.pull_b_low),
                        8'(rsp_pull_b_low));
            check_field("recv_valid", 8'(oldest_result.link.recv_valid),
                        8'(rsp_recv_valid));
            check_field("recv_byte", oldest_result.link.recv_byte, rsp_recv_byte);
            check_field("queue_overflow", 8'(oldest_result.queue_overflow),
                        8'(rsp_queue_overflow));
            check_field("queue_fill", 8'(oldest_result.queue_fill), 8'(rsp_queue_fill));
            check_field("noise_tally", oldest_result.link.noise_tally, rsp_noise_tally);
            check_field("timeout_tally", oldest_result.link.timeout_tally, rsp_timeout_tally);
            check_field("link_busy", 8'(oldest_result.link.link_busy), 8'(rsp_link_busy));
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 6;
      recv_idle_pct = 78;
      test_directed_cases();
      test_timeout_settings();
      test_random_traffic(6, 78);
      test_random_traffic(78, 6);
      test_random_traffic(0, 0);
      test_backpressure();
      test_random_traffic(0, 0);
      settle_link();
      $display("Checked %0d of %0d transactions across wait limits and idle patterns.",
               checked_count, sent_count);
      $display("Bytes received %0d, queue overflows %0d, handshake timeouts %0d.",
               bytes_received, overflow_count, timeout_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
